// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- rtl/gzmfc_pkg.sv -----
// Types, codes and the CRC-32 byte update for the gzip member frame checker.
package gzmfc_pkg;

   // request operations
   localparam logic [1:0] OP_FRAME    = 2'd0;
   localparam logic [1:0] OP_DATA     = 2'd1;
   localparam logic [1:0] OP_BODY_END = 2'd2;
   localparam logic [1:0] OP_EOI      = 2'd3;

   // response status codes
   localparam logic [2:0] ST_NEED      = 3'd0;
   localparam logic [2:0] ST_DONE      = 3'd1;
   localparam logic [2:0] ST_TRUNC     = 3'd2;
   localparam logic [2:0] ST_MALFORMED = 3'd3;
   localparam logic [2:0] ST_UNSUPP    = 3'd4;
   localparam logic [2:0] ST_CHECKSUM  = 3'd5;
   localparam logic [2:0] ST_TRAILING  = 3'd6;
   localparam logic [2:0] ST_LIMIT     = 3'd7;

   // parser modes
   localparam logic [3:0] M_FIXED   = 4'd0;
   localparam logic [3:0] M_XLEN    = 4'd1;
   localparam logic [3:0] M_EXTRA   = 4'd2;
   localparam logic [3:0] M_NAME    = 4'd3;
   localparam logic [3:0] M_COMMENT = 4'd4;
   localparam logic [3:0] M_HCRC    = 4'd5;
   localparam logic [3:0] M_BODY    = 4'd6;
   localparam logic [3:0] M_TRAILER = 4'd7;
   localparam logic [3:0] M_BETWEEN = 4'd8;
   localparam logic [3:0] M_DONE    = 4'd9;
   localparam logic [3:0] M_ERROR   = 4'd10;

   // header flag bits
   localparam logic [7:0] FL_HCRC     = 8'h02;
   localparam logic [7:0] FL_EXTRA    = 8'h04;
   localparam logic [7:0] FL_NAME     = 8'h08;
   localparam logic [7:0] FL_COMMENT  = 8'h10;
   localparam logic [7:0] FL_RESERVED = 8'he0;

   localparam logic [7:0]  MAGIC_ID1      = 8'h1f;
   localparam logic [7:0]  MAGIC_ID2      = 8'h8b;
   localparam logic [15:0] METHOD_DEFLATE = 16'd8;
   localparam logic [3:0]  FIXED_LEN      = 4'd10;
   localparam logic [3:0]  TRAILER_LEN    = 4'd8;
   localparam logic [31:0] CRC_POLY       = 32'hedb88320;

   typedef struct packed {
      logic [2:0]  status;
      logic        in_body;
      logic [31:0] member_count;
      logic [63:0] total_output;
   } rsp_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] flags;
   } sect_type;

   // Reflected CRC-32 over one byte, one bit a step.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/gzmfc_core.sv -----
// Member parser state: header walk, body CRC and size, trailer check.
module gzmfc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           operation,
   input  logic [7:0]           byte_value,
   input  logic [63:0]          max_total,
   output gzmfc_pkg::rsp_type   result
);

   logic [3:0]  mode_ff,  mode_in;
   logic [7:0]  pf_ff,    pf_in;
   logic [3:0]  hc_ff,    hc_in;
   logic [15:0] sb_ff,    sb_in;
   logic        sc_ff,    sc_in;
   logic [15:0] el_ff,    el_in;
   logic [31:0] hcrc_ff,  hcrc_in;
   logic [31:0] bcrc_ff,  bcrc_in;
   logic [31:0] mb_ff,    mb_in;
   logic [63:0] oc_ff,    oc_in;
   logic [31:0] md_ff,    md_in;
   logic [63:0] tb_ff,    tb_in;
   logic [3:0]  tc_ff,    tc_in;
   logic [2:0]  fs_ff,    fs_in;

   gzmfc_pkg::sect_type sect;

   // Pick the next optional header section still pending.
   function automatic gzmfc_pkg::sect_type next_section(input logic [7:0] flags);
      gzmfc_pkg::sect_type s;
      s.flags = flags;
      if ((flags & gzmfc_pkg::FL_EXTRA) != 8'd0) begin
         s.flags = flags & ~gzmfc_pkg::FL_EXTRA;
         s.mode  = gzmfc_pkg::M_XLEN;
      end else if ((flags & gzmfc_pkg::FL_NAME) != 8'd0) begin
         s.flags = flags & ~gzmfc_pkg::FL_NAME;
         s.mode  = gzmfc_pkg::M_NAME;
      end else if ((flags & gzmfc_pkg::FL_COMMENT) != 8'd0) begin
         s.flags = flags & ~gzmfc_pkg::FL_COMMENT;
         s.mode  = gzmfc_pkg::M_COMMENT;
      end else if ((flags & gzmfc_pkg::FL_HCRC) != 8'd0) begin
         s.flags = flags & ~gzmfc_pkg::FL_HCRC;
         s.mode  = gzmfc_pkg::M_HCRC;
      end else begin
         s.mode  = gzmfc_pkg::M_BODY;
      end
      return s;
   endfunction

   assign sect = next_section(pf_ff);

   // Work out the state after one request
   always_comb begin
      mode_in = mode_ff;
      pf_in   = pf_ff;
      hc_in   = hc_ff;
      sb_in   = sb_ff;
      sc_in   = sc_ff;
      el_in   = el_ff;
      hcrc_in = hcrc_ff;
      bcrc_in = bcrc_ff;
      mb_in   = mb_ff;
      oc_in   = oc_ff;
      md_in   = md_ff;
      tb_in   = tb_ff;
      tc_in   = tc_ff;
      fs_in   = fs_ff;

      if (accept && !(mode_ff inside {gzmfc_pkg::M_DONE, gzmfc_pkg::M_ERROR})) begin
         case (operation)
            gzmfc_pkg::OP_FRAME: begin
               // start a fresh member on the first framing byte after a trailer
               if (mode_ff == gzmfc_pkg::M_BETWEEN) begin
                  mode_in = gzmfc_pkg::M_FIXED;
                  pf_in   = 8'd0;
                  hc_in   = 4'd0;
                  sb_in   = 16'd0;
                  sc_in   = 1'b0;
                  el_in   = 16'd0;
                  hcrc_in = 32'hffffffff;
                  bcrc_in = 32'hffffffff;
                  mb_in   = 32'd0;
                  tb_in   = 64'd0;
                  tc_in   = 4'd0;
               end
               case (mode_in)
                  gzmfc_pkg::M_FIXED: begin
                     hc_in   = hc_in + 4'd1;
                     hcrc_in = gzmfc_pkg::crc_byte(hcrc_in, byte_value);
                     if ((hc_in == 4'd1 && byte_value != gzmfc_pkg::MAGIC_ID1) ||
                         (hc_in == 4'd2 && byte_value != gzmfc_pkg::MAGIC_ID2)) begin
                        mode_in = gzmfc_pkg::M_ERROR;
                        fs_in   = (md_ff == 32'd0) ? gzmfc_pkg::ST_MALFORMED
                                                   : gzmfc_pkg::ST_TRAILING;
                     end else begin
                        if (hc_in == 4'd3) begin
                           sb_in = {8'd0, byte_value};
                        end
                        if (hc_in == 4'd4) begin
                           pf_in = byte_value;
                        end
                        if (hc_in == gzmfc_pkg::FIXED_LEN) begin
                           if (sb_in != gzmfc_pkg::METHOD_DEFLATE) begin
                              mode_in = gzmfc_pkg::M_ERROR;
                              fs_in   = gzmfc_pkg::ST_UNSUPP;
                           end else if ((pf_in & gzmfc_pkg::FL_RESERVED) != 8'd0) begin
                              mode_in = gzmfc_pkg::M_ERROR;
                              fs_in   = gzmfc_pkg::ST_MALFORMED;
                           end else begin
                              mode_in = sect.mode;
                              pf_in   = sect.flags;
                              sc_in   = 1'b0;
                           end
                        end
                     end
                  end
                  gzmfc_pkg::M_XLEN: begin
                     hcrc_in = gzmfc_pkg::crc_byte(hcrc_ff, byte_value);
                     if (!sc_ff) begin
                        sb_in = {8'd0, byte_value};
                        sc_in = 1'b1;
                     end else begin
                        el_in = {byte_value, sb_ff[7:0]};
                        sc_in = 1'b0;
                        if (el_in == 16'd0) begin
                           mode_in = sect.mode;
                           pf_in   = sect.flags;
                        end else begin
                           mode_in = gzmfc_pkg::M_EXTRA;
                        end
                     end
                  end
                  gzmfc_pkg::M_EXTRA: begin
                     hcrc_in = gzmfc_pkg::crc_byte(hcrc_ff, byte_value);
                     el_in   = el_ff - 16'd1;
                     if (el_in == 16'd0) begin
                        mode_in = sect.mode;
                        pf_in   = sect.flags;
                        sc_in   = 1'b0;
                     end
                  end
                  gzmfc_pkg::M_NAME, gzmfc_pkg::M_COMMENT: begin
                     hcrc_in = gzmfc_pkg::crc_byte(hcrc_ff, byte_value);
                     if (byte_value == 8'd0) begin
                        mode_in = sect.mode;
                        pf_in   = sect.flags;
                        sc_in   = 1'b0;
                     end
                  end
                  gzmfc_pkg::M_HCRC: begin
                     if (!sc_ff) begin
                        sb_in = {8'd0, byte_value};
                        sc_in = 1'b1;
                     end else begin
                        sb_in = {byte_value, sb_ff[7:0]};
                        sc_in = 1'b0;
                        if (sb_in != ~hcrc_ff[15:0]) begin
                           mode_in = gzmfc_pkg::M_ERROR;
                           fs_in   = gzmfc_pkg::ST_CHECKSUM;
                        end else begin
                           mode_in = gzmfc_pkg::M_BODY;
                        end
                     end
                  end
                  gzmfc_pkg::M_TRAILER: begin
                     // little-endian CRC-32 then ISIZE
                     for (int i = 0; i < 8; i++) begin
                        if (tc_ff[2:0] == 3'(i)) begin
                           tb_in[i*8 +: 8] = tb_ff[i*8 +: 8] | byte_value;
                        end
                     end
                     tc_in = tc_ff + 4'd1;
                     if (tc_in == gzmfc_pkg::TRAILER_LEN) begin
                        if (tb_in[31:0] != ~bcrc_ff || tb_in[63:32] != mb_ff) begin
                           mode_in = gzmfc_pkg::M_ERROR;
                           fs_in   = gzmfc_pkg::ST_CHECKSUM;
                        end else begin
                           md_in   = md_ff + 32'd1;
                           mode_in = gzmfc_pkg::M_BETWEEN;
                        end
                     end
                  end
                  default: begin
                     // body: compressed bytes belong to the inflate core
                  end
               endcase
            end
            gzmfc_pkg::OP_DATA: begin
               if (mode_ff != gzmfc_pkg::M_BODY) begin
                  mode_in = gzmfc_pkg::M_ERROR;
                  fs_in   = gzmfc_pkg::ST_MALFORMED;
               end else if (oc_ff >= max_total) begin
                  mode_in = gzmfc_pkg::M_ERROR;
                  fs_in   = gzmfc_pkg::ST_LIMIT;
               end else begin
                  bcrc_in = gzmfc_pkg::crc_byte(bcrc_ff, byte_value);
                  mb_in   = mb_ff + 32'd1;
                  oc_in   = oc_ff + 64'd1;
               end
            end
            gzmfc_pkg::OP_BODY_END: begin
               if (mode_ff != gzmfc_pkg::M_BODY) begin
                  mode_in = gzmfc_pkg::M_ERROR;
                  fs_in   = gzmfc_pkg::ST_MALFORMED;
               end else begin
                  tb_in   = 64'd0;
                  tc_in   = 4'd0;
                  mode_in = gzmfc_pkg::M_TRAILER;
               end
            end
            default: begin
               // end of input
               if (mode_ff == gzmfc_pkg::M_BETWEEN) begin
                  mode_in = gzmfc_pkg::M_DONE;
                  fs_in   = gzmfc_pkg::ST_DONE;
               end else begin
                  mode_in = gzmfc_pkg::M_ERROR;
                  fs_in   = gzmfc_pkg::ST_TRUNC;
               end
            end
         endcase
      end
   end

   // Form the response from the updated state
   always_comb begin
      if (mode_in == gzmfc_pkg::M_DONE) begin
         result.status = gzmfc_pkg::ST_DONE;
      end else if (mode_in == gzmfc_pkg::M_ERROR) begin
         result.status = fs_in;
      end else begin
         result.status = gzmfc_pkg::ST_NEED;
      end
      result.in_body      = (mode_in == gzmfc_pkg::M_BODY);
      result.member_count = md_in;
      result.total_output = oc_in;
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gzmfc_pkg::M_FIXED;
         pf_ff   <= 8'd0;
         hc_ff   <= 4'd0;
         sb_ff   <= 16'd0;
         sc_ff   <= 1'b0;
         el_ff   <= 16'd0;
         hcrc_ff <= 32'hffffffff;
         bcrc_ff <= 32'hffffffff;
         mb_ff   <= 32'd0;
         oc_ff   <= 64'd0;
         md_ff   <= 32'd0;
         tb_ff   <= 64'd0;
         tc_ff   <= 4'd0;
         fs_ff   <= gzmfc_pkg::ST_NEED;
      end else begin
         mode_ff <= mode_in;
         pf_ff   <= pf_in;
         hc_ff   <= hc_in;
         sb_ff   <= sb_in;
         sc_ff   <= sc_in;
         el_ff   <= el_in;
         hcrc_ff <= hcrc_in;
         bcrc_ff <= bcrc_in;
         mb_ff   <= mb_in;
         oc_ff   <= oc_in;
         md_ff   <= md_in;
         tb_ff   <= tb_in;
         tc_ff   <= tc_in;
         fs_ff   <= fs_in;
      end
   end

endmodule

// ----- rtl/gzmfc_rsp_skid.sv -----
// Two-deep response stage: output register plus skid register.
module gzmfc_rsp_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gzmfc_pkg::rsp_type push_data,
   output logic               push_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output gzmfc_pkg::rsp_type out_data
);

   logic               out_v_ff, out_v_in;
   gzmfc_pkg::rsp_type out_d_ff, out_d_in;
   logic               sk_v_ff,  sk_v_in;
   gzmfc_pkg::rsp_type sk_d_ff,  sk_d_in;
   logic               pop;

   assign pop        = out_v_ff && out_ready;
   assign push_ready = !sk_v_ff;
   assign out_valid  = out_v_ff;
   assign out_data   = out_d_ff;

   // Refill output from the skid, else the push; or skid the push
   always_comb begin
      out_v_in = out_v_ff;
      out_d_in = out_d_ff;
      sk_v_in  = sk_v_ff;
      sk_d_in  = sk_d_ff;
      if (pop || !out_v_ff) begin
         if (sk_v_ff) begin
            out_v_in = 1'b1;
            out_d_in = sk_d_ff;
            sk_v_in  = 1'b0;
         end else begin
            out_v_in = push;
            out_d_in = push_data;
         end
      end else if (push) begin
         sk_v_in = 1'b1;
         sk_d_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
      out_d_ff <= out_d_in;
      sk_d_ff  <= sk_d_in;
   end

endmodule

// ----- rtl/gzip_member_frame_checker.sv -----
// gzip member frame checker: one request per cycle while req_ready is high,
// one response per request. Each accepted request (framing byte, decompressed
// byte, body end or end of input) updates the parser state in the cycle it is
// accepted, and its response is registered into the output register, or into
// the skid register while the output register is held. A two-deep output stage
// lets two responses wait; req_ready drops only while both are held by a stalled
// rsp_ready. The header CRC, body CRC-32 and size checks each take one
// byte update per accepted request. The output byte cap, written through the
// always-ready csr port, is compared live against the running output count.
module gzip_member_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_in_body,
   output logic [31:0] rsp_member_count,
   output logic [63:0] rsp_total_output,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_max_total
);

   logic [63:0]        limit_ff;
   logic               accept;
   gzmfc_pkg::rsp_type result;
   gzmfc_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // Hold the output byte cap register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 64'hffffffffffffffff;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_max_total;
      end
   end

   gzmfc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .byte_value   (req_byte_value),
      .max_total    (limit_ff),
      .result       (result)
   );

   gzmfc_rsp_skid u_rsp (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp)
   );

   assign rsp_status       = rsp.status;
   assign rsp_in_body      = rsp.in_body;
   assign rsp_member_count = rsp.member_count;
   assign rsp_total_output = rsp.total_output;

endmodule

// ----- rtl/gzmfc_checker.sv -----
// Port-level assertions for the gzip member frame checker, bound to the top.
`include "assert_macros.svh"

module gzmfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_in_body,
   input logic [63:0] rsp_total_output
);

   // a stalled response holds its status and output total
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_total_output))

   // input backs up only behind a waiting response
   `ASSERT_SAME_CYCLE(a_ready_stall, clock, reset, !req_ready, rsp_valid)

   // body routing is only flagged while parsing continues
   `ASSERT_SAME_CYCLE(a_body_need, clock, reset, rsp_valid && rsp_in_body, rsp_status == gzmfc_pkg::ST_NEED)

   // a final status, once taken, repeats on any response that follows straight on
   `ASSERT_NEXT_CYCLE(a_final_sticky, clock, reset, rsp_valid && rsp_ready && rsp_status != gzmfc_pkg::ST_NEED, !rsp_valid || rsp_status == $past(rsp_status))

endmodule

bind gzip_member_frame_checker gzmfc_checker u_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the gzip member frame checker.
module tb_top;

   localparam logic [7:0] FL_TEXT     = 8'h01;
   localparam logic [7:0] FL_OPTIONAL = FL_TEXT | gzmfc_pkg::FL_HCRC | gzmfc_pkg::FL_EXTRA |
                                        gzmfc_pkg::FL_NAME | gzmfc_pkg::FL_COMMENT;
   localparam int         STALL_LIMIT = 2000;
   localparam int         LONG_HOLD   = 80;

   // faults that may close the stream
   typedef enum int {
      FLAW_NONE, FLAW_MAGIC, FLAW_METHOD, FLAW_RESERVED, FLAW_HCRC, FLAW_TRAILER,
      FLAW_CUT, FLAW_DATA_OUT, FLAW_END_OUT, FLAW_LIMIT, FLAW_FINISH
   } flaw_type;

   // Tracks the parser state and holds the responses still owed by the block.
   class member_scoreboard;
      logic [63:0]        max_total;
      logic [3:0]         mode;
      logic [7:0]         flags_left;
      logic [3:0]         fixed_seen;
      logic [15:0]        word_buf;
      logic               word_half;
      logic [15:0]        extra_left;
      logic [31:0]        hdr_crc;
      logic [31:0]        body_crc;
      logic [31:0]        body_size;
      logic [63:0]        total_bytes;
      logic [31:0]        members_ok;
      logic [63:0]        trailer_bits;
      logic [3:0]         trailer_seen;
      logic [2:0]         final_code;
      gzmfc_pkg::rsp_type awaited[$];
      int                 failures;

      // reflected CRC-32, feeding the byte in one bit at a time
      static function logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
         logic [31:0] r;
         int          k;
         r = crc;
         for (k = 0; k < 8; k++) begin
            r = (r >> 1) ^ ({32{r[0] ^ b[k]}} & gzmfc_pkg::CRC_POLY);
         end
         return r;
      endfunction

      function void open_member();
         mode         = gzmfc_pkg::M_FIXED;
         flags_left   = '0;
         fixed_seen   = '0;
         word_buf     = '0;
         word_half    = 1'b0;
         extra_left   = '0;
         hdr_crc      = '1;
         body_crc     = '1;
         body_size    = '0;
         trailer_bits = '0;
         trailer_seen = '0;
      endfunction

      function void reset_state();
         max_total = '1;
         open_member();
         total_bytes = '0;
         members_ok  = '0;
         final_code  = gzmfc_pkg::ST_NEED;
         failures    = 0;
      endfunction

      function void fail(logic [2:0] code);
         mode       = gzmfc_pkg::M_ERROR;
         final_code = code;
      endfunction

      // move on to the next optional header section, in flag order
      function void next_section();
         word_half = 1'b0;
         if ((flags_left & gzmfc_pkg::FL_EXTRA) != 0) begin
            flags_left &= ~gzmfc_pkg::FL_EXTRA;
            mode = gzmfc_pkg::M_XLEN;
         end else if ((flags_left & gzmfc_pkg::FL_NAME) != 0) begin
            flags_left &= ~gzmfc_pkg::FL_NAME;
            mode = gzmfc_pkg::M_NAME;
         end else if ((flags_left & gzmfc_pkg::FL_COMMENT) != 0) begin
            flags_left &= ~gzmfc_pkg::FL_COMMENT;
            mode = gzmfc_pkg::M_COMMENT;
         end else if ((flags_left & gzmfc_pkg::FL_HCRC) != 0) begin
            flags_left &= ~gzmfc_pkg::FL_HCRC;
            mode = gzmfc_pkg::M_HCRC;
         end else begin
            mode = gzmfc_pkg::M_BODY;
         end
      endfunction

      function void take_framing_byte(logic [7:0] b);
         if (mode == gzmfc_pkg::M_BETWEEN) open_member();
         case (mode)
            gzmfc_pkg::M_FIXED: begin
               fixed_seen = fixed_seen + 4'd1;
               hdr_crc = crc32_update(hdr_crc, b);
               if ((fixed_seen == 4'd1 && b != gzmfc_pkg::MAGIC_ID1) ||
                   (fixed_seen == 4'd2 && b != gzmfc_pkg::MAGIC_ID2)) begin
                  fail(members_ok == 0 ? gzmfc_pkg::ST_MALFORMED : gzmfc_pkg::ST_TRAILING);
               end else begin
                  if (fixed_seen == 4'd3) word_buf = {8'd0, b};
                  if (fixed_seen == 4'd4) flags_left = b;
                  // method is judged before the reserved flags
                  if (fixed_seen == gzmfc_pkg::FIXED_LEN) begin
                     if (word_buf != gzmfc_pkg::METHOD_DEFLATE) begin
                        fail(gzmfc_pkg::ST_UNSUPP);
                     end else if ((flags_left & gzmfc_pkg::FL_RESERVED) != 0) begin
                        fail(gzmfc_pkg::ST_MALFORMED);
                     end else begin
                        next_section();
                     end
                  end
               end
            end
            gzmfc_pkg::M_XLEN: begin
               hdr_crc = crc32_update(hdr_crc, b);
               if (!word_half) begin
                  word_buf  = {8'd0, b};
                  word_half = 1'b1;
               end else begin
                  extra_left = {b, word_buf[7:0]};
                  word_half  = 1'b0;
                  if (extra_left == 0) next_section();
                  else mode = gzmfc_pkg::M_EXTRA;
               end
            end
            gzmfc_pkg::M_EXTRA: begin
               hdr_crc = crc32_update(hdr_crc, b);
               extra_left = extra_left - 16'd1;
               if (extra_left == 0) next_section();
            end
            gzmfc_pkg::M_NAME, gzmfc_pkg::M_COMMENT: begin
               hdr_crc = crc32_update(hdr_crc, b);
               if (b == 8'd0) next_section();
            end
            gzmfc_pkg::M_HCRC: begin
               if (!word_half) begin
                  word_buf  = {8'd0, b};
                  word_half = 1'b1;
               end else begin
                  word_buf  = {b, word_buf[7:0]};
                  word_half = 1'b0;
                  if (word_buf != ~hdr_crc[15:0]) fail(gzmfc_pkg::ST_CHECKSUM);
                  else mode = gzmfc_pkg::M_BODY;
               end
            end
            gzmfc_pkg::M_TRAILER: begin
               trailer_bits[8 * trailer_seen[2:0] +: 8] = b;
               trailer_seen = trailer_seen + 4'd1;
               if (trailer_seen == gzmfc_pkg::TRAILER_LEN) begin
                  if (trailer_bits[31:0] != ~body_crc ||
                      trailer_bits[63:32] != body_size) begin
                     fail(gzmfc_pkg::ST_CHECKSUM);
                  end else begin
                     members_ok = members_ok + 32'd1;
                     mode = gzmfc_pkg::M_BETWEEN;
                  end
               end
            end
            // body: compressed bytes belong to the inflate core
            default: ;
         endcase
      endfunction

      // advance the parser by one accepted request and queue its response
      function void note_request(logic [1:0] op, logic [7:0] b);
         gzmfc_pkg::rsp_type r;
         if (mode != gzmfc_pkg::M_DONE && mode != gzmfc_pkg::M_ERROR) begin
            case (op)
               gzmfc_pkg::OP_FRAME: take_framing_byte(b);
               gzmfc_pkg::OP_DATA: begin
                  if (mode != gzmfc_pkg::M_BODY) begin
                     fail(gzmfc_pkg::ST_MALFORMED);
                  end else if (total_bytes >= max_total) begin
                     fail(gzmfc_pkg::ST_LIMIT);
                  end else begin
                     body_crc    = crc32_update(body_crc, b);
                     body_size   = body_size + 32'd1;
                     total_bytes = total_bytes + 64'd1;
                  end
               end
               gzmfc_pkg::OP_BODY_END: begin
                  if (mode != gzmfc_pkg::M_BODY) begin
                     fail(gzmfc_pkg::ST_MALFORMED);
                  end else begin
                     trailer_bits = '0;
                     trailer_seen = '0;
                     mode = gzmfc_pkg::M_TRAILER;
                  end
               end
               default: begin
                  if (mode == gzmfc_pkg::M_BETWEEN) begin
                     mode = gzmfc_pkg::M_DONE;
                     final_code = gzmfc_pkg::ST_DONE;
                  end else begin
                     fail(gzmfc_pkg::ST_TRUNC);
                  end
               end
            endcase
         end
         if (mode == gzmfc_pkg::M_DONE) r.status = gzmfc_pkg::ST_DONE;
         else if (mode == gzmfc_pkg::M_ERROR) r.status = final_code;
         else r.status = gzmfc_pkg::ST_NEED;
         r.in_body      = (mode == gzmfc_pkg::M_BODY);
         r.member_count = members_ok;
         r.total_output = total_bytes;
         awaited.push_back(r);
      endfunction

      function void compare_field(string label, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            failures++;
         end
      endfunction

      // check one response against the oldest one owed
      function void check_response(logic [2:0] status, logic in_body,
                                   logic [31:0] member_count, logic [63:0] total_output);
         gzmfc_pkg::rsp_type w;
         if (awaited.size() == 0) begin
            $display("%0t: response with none owed, status %0d, total %0h",
                     $time, status, total_output);
            failures++;
            return;
         end
         w = awaited.pop_front();
         compare_field("status", 64'(w.status), 64'(status));
         compare_field("in_body", 64'(w.in_body), 64'(in_body));
         compare_field("member_count", 64'(w.member_count), 64'(member_count));
         compare_field("total_output", w.total_output, total_output);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = gzmfc_pkg::OP_FRAME;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_in_body;
   logic [31:0] rsp_member_count;
   logic [63:0] rsp_total_output;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_max_total = '0;

   member_scoreboard board;
   int          requests_sent = 0;
   int          responses_seen = 0;
   int          tx_gap_max = 0;
   int          rx_gap_max = 0;
   int          stall_cycles = 0;
   logic [31:0] gen_hdr_crc;
   int          intrude_after = -1;
   logic [1:0]  intrude_op = gzmfc_pkg::OP_EOI;

   gzip_member_frame_checker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_in_body      (rsp_in_body),
      .rsp_member_count (rsp_member_count),
      .rsp_total_output (rsp_total_output),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_total    (csr_max_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // byte values leaning towards the extremes
   function automatic logic [7:0] draw_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // offer one request and hold it until the block takes it
   task automatic send_request(input logic [1:0] op, input logic [7:0] b);
      int gap;
      if (requests_sent % 64 == 0) tx_gap_max = $urandom_range(0, 1) ? 13 : 0;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_byte_value <= b;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, b);
      requests_sent++;
      @(negedge clock);
   endtask

   // slip in the armed out-of-place request once its position comes up
   task automatic send_member_item(input logic [1:0] op, input logic [7:0] b);
      if (intrude_after == 0) send_request(intrude_op, draw_byte());
      if (intrude_after >= 0) intrude_after--;
      send_request(op, b);
   endtask

   task automatic send_header_byte(input logic [7:0] b);
      gen_hdr_crc = member_scoreboard::crc32_update(gen_hdr_crc, b);
      send_member_item(gzmfc_pkg::OP_FRAME, b);
   endtask

   // build one member with correct checks unless a fault is asked for
   task automatic send_member(input logic [7:0] flags, input int xlen, input int name_len,
                              input int comment_len, input int body_len, input flaw_type flaw);
      logic [7:0]  id1;
      logic [7:0]  id2;
      logic [7:0]  method;
      logic [7:0]  fl;
      logic [7:0]  b;
      logic [15:0] hcrc;
      logic [31:0] body_crc;
      logic [63:0] trailer;
      int          i;
      id1 = gzmfc_pkg::MAGIC_ID1;
      id2 = gzmfc_pkg::MAGIC_ID2;
      method = 8'(gzmfc_pkg::METHOD_DEFLATE);
      fl = flags;
      body_crc = '1;
      gen_hdr_crc = '1;
      case (flaw)
         FLAW_MAGIC: begin
            if ($urandom_range(0, 1)) id1 = gzmfc_pkg::MAGIC_ID1 ^ 8'($urandom_range(1, 255));
            else id2 = gzmfc_pkg::MAGIC_ID2 ^ 8'($urandom_range(1, 255));
         end
         FLAW_METHOD: begin
            method = method ^ 8'($urandom_range(1, 255));
            fl = fl | (8'($urandom_range(0, 7)) << 5);
         end
         FLAW_RESERVED: fl = fl | (8'($urandom_range(1, 7)) << 5);
         FLAW_HCRC: fl = fl | gzmfc_pkg::FL_HCRC;
         default: ;
      endcase
      send_header_byte(id1);
      send_header_byte(id2);
      send_header_byte(method);
      send_header_byte(fl);
      repeat (6) send_header_byte(draw_byte());
      if ((fl & gzmfc_pkg::FL_EXTRA) != 0) begin
         send_header_byte(8'(xlen));
         send_header_byte(8'(xlen >> 8));
         repeat (xlen) send_header_byte(draw_byte());
      end
      if ((fl & gzmfc_pkg::FL_NAME) != 0) begin
         repeat (name_len) send_header_byte(8'($urandom_range(1, 255)));
         send_header_byte(8'h00);
      end
      if ((fl & gzmfc_pkg::FL_COMMENT) != 0) begin
         repeat (comment_len) send_header_byte(8'($urandom_range(1, 255)));
         send_header_byte(8'h00);
      end
      if ((fl & gzmfc_pkg::FL_HCRC) != 0) begin
         hcrc = ~gen_hdr_crc[15:0];
         if (flaw == FLAW_HCRC) hcrc = hcrc ^ (16'd1 << $urandom_range(0, 15));
         send_member_item(gzmfc_pkg::OP_FRAME, hcrc[7:0]);
         send_member_item(gzmfc_pkg::OP_FRAME, hcrc[15:8]);
      end
      // body: mix in compressed bytes, which the checker must ignore
      repeat (body_len) begin
         if ($urandom_range(0, 4) == 0) send_member_item(gzmfc_pkg::OP_FRAME, draw_byte());
         b = draw_byte();
         body_crc = member_scoreboard::crc32_update(body_crc, b);
         send_member_item(gzmfc_pkg::OP_DATA, b);
      end
      send_member_item(gzmfc_pkg::OP_BODY_END, 8'($urandom));
      trailer = {32'(body_len), ~body_crc};
      if (flaw == FLAW_TRAILER) trailer = trailer ^ (64'd1 << $urandom_range(0, 63));
      for (i = 0; i < 8; i++) send_member_item(gzmfc_pkg::OP_FRAME, trailer[8 * i +: 8]);
   endtask

   // mostly small sections and bodies, with the odd long extra field
   task automatic send_random_member(input flaw_type flaw, input bit empty_body);
      int xlen;
      int body_len;
      case ($urandom_range(0, 39))
         0: xlen = $urandom_range(256, 300);
         1, 2, 3, 4, 5, 6, 7: xlen = $urandom_range(6, 24);
         default: xlen = $urandom_range(0, 5);
      endcase
      body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
      if (empty_body) body_len = 0;
      if (flaw == FLAW_LIMIT) body_len = $urandom_range(5, 20);
      send_member(8'($urandom) & FL_OPTIONAL, xlen, $urandom_range(0, 6),
                  $urandom_range(0, 6), body_len, flaw);
   endtask

   // drop valid and hold until every owed response has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic write_max_total(input logic [63:0] value);
      wait_idle();
      csr_valid     <= 1'b1;
      csr_max_total <= value;
      do @(posedge clock); while (!csr_ready);
      board.max_total = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response side: random stalls, bursts without stalls, one long hold
   initial begin : response_sink
      int gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (responses_seen % 64 == 0) rx_gap_max = $urandom_range(0, 1) ? 13 : 0;
         gap = (responses_seen == 300) ? LONG_HOLD : $urandom_range(0, rx_gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_response(rsp_status, rsp_in_body, rsp_member_count, rsp_total_output);
         responses_seen++;
         @(negedge clock);
      end
   end

   // end the run if no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      flaw_type last_flaw;
      board = new();
      board.reset_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every optional section, empty extra field and name, then a bare member
      send_member(FL_OPTIONAL, 0, 0, 3, 4, FLAW_NONE);
      send_member(8'h00, 0, 0, 0, 0, FLAW_NONE);

      // zero cap: only empty bodies get through
      write_max_total('0);
      repeat (2) send_random_member(FLAW_NONE, 1'b1);

      write_max_total('1);
      while (requests_sent < 600) send_random_member(FLAW_NONE, 1'b0);

      write_max_total({1'b0, 31'($urandom), 32'($urandom)} | 64'h0000_1000_0000_0000);
      while (requests_sent < 1250) send_random_member(FLAW_NONE, 1'b0);

      // close the stream with one fault chosen by the seed
      last_flaw = flaw_type'($urandom_range(FLAW_MAGIC, FLAW_FINISH));
      case (last_flaw)
         FLAW_LIMIT: write_max_total(board.total_bytes + 64'($urandom_range(0, 3)));
         FLAW_CUT: begin
            intrude_op = gzmfc_pkg::OP_EOI;
            intrude_after = $urandom_range(0, 60);
         end
         FLAW_DATA_OUT: begin
            intrude_op = gzmfc_pkg::OP_DATA;
            intrude_after = $urandom_range(0, 9);
         end
         FLAW_END_OUT: begin
            intrude_op = gzmfc_pkg::OP_BODY_END;
            intrude_after = $urandom_range(0, 9);
         end
         default: ;
      endcase
      if (last_flaw == FLAW_FINISH) send_request(gzmfc_pkg::OP_EOI, draw_byte());
      else send_random_member(last_flaw, 1'b0);
      if (intrude_after >= 0) send_request(intrude_op, draw_byte());

      // anything after a final status must repeat it
      repeat (30) send_request(2'($urandom_range(0, 3)), draw_byte());

      wait_idle();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- gzip_member_frame_checker.f -----
+incdir+rtl
rtl/gzmfc_pkg.sv
rtl/gzmfc_core.sv
rtl/gzmfc_rsp_skid.sv
rtl/gzip_member_frame_checker.sv
rtl/gzmfc_checker.sv
tb/tb_top.sv
